// ===== hw/rtl/mm521_pkg.sv =====
// ----------------------------------------------------------------------------
// mm521_pkg
// Shared widths, masks, types and state codes of the modulo 2^521-1 multiplier.
// ----------------------------------------------------------------------------
package mm521_pkg;

	localparam int LIMB_COUNT = 18;
	localparam int LIMB_BITS  = 29;
	localparam int LIMB_W     = LIMB_BITS + 1;
	localparam int IDX_W      = 5;
	localparam int DIG_W      = 15;
	localparam int PP_W       = LIMB_W + DIG_W;
	localparam int ACC_W      = 64;
	localparam int CARRY_W    = 36;
	localparam int SHAMT_W    = 5;

	localparam logic [LIMB_W-1:0] MASK_LOW = 30'h3fffffff;
	localparam logic [LIMB_W-1:0] MASK_MID = 30'h1fffffff;
	localparam logic [LIMB_W-1:0] MASK_TOP = 30'h0fffffff;

	localparam logic [IDX_W-1:0] FIRST_POS = '0;
	localparam logic [IDX_W-1:0] LAST_POS  = IDX_W'(LIMB_COUNT - 1);
	localparam logic [IDX_W-1:0] POS_COUNT = IDX_W'(LIMB_COUNT);

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_ISSUE,
		SEQ_DRAIN,
		SEQ_OUT
	} seq_state_t;

	typedef enum logic [1:0] {
		CC_COL,
		CC_FOLD,
		CC_FIX
	} cc_state_t;

	// one multiply-accumulate term handed to the digit unit
	typedef struct packed {
		logic load;
		logic dbl;
		logic first;
		logic last;
	} mac_ctl_t;

	typedef struct packed {
		logic             valid;
		logic [ACC_W-1:0] sum;
	} mac_res_t;

	function automatic logic [LIMB_W-1:0] limb_mask(input logic [IDX_W-1:0] pos);
		logic [LIMB_W-1:0] m;
		m = MASK_MID;
		if (pos == FIRST_POS)
			m = MASK_LOW;
		else if (pos == LAST_POS)
			m = MASK_TOP;
		return m;
	endfunction

endpackage

// ===== hw/rtl/mm521_limb_file.sv =====
// ----------------------------------------------------------------------------
// mm521_limb_file
// Operand limb stores for X and Y, masked by position on write.
// ----------------------------------------------------------------------------
module mm521_limb_file import mm521_pkg::*; (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_idx,
	input  logic [LIMB_W-1:0] wr_x,
	input  logic [LIMB_W-1:0] wr_y,
	input  logic [IDX_W-1:0]  rd_x_idx,
	input  logic [IDX_W-1:0]  rd_y_idx,
	output logic [LIMB_W-1:0] x_rd,
	output logic [LIMB_W-1:0] y_rd
);

	logic [LIMB_W-1:0] x_q [LIMB_COUNT];
	logic [LIMB_W-1:0] y_q [LIMB_COUNT];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			x_q[wr_idx] <= wr_x & limb_mask(wr_idx);
			y_q[wr_idx] <= wr_y & limb_mask(wr_idx);
		end
	end

	assign x_rd = x_q[rd_x_idx];
	assign y_rd = y_q[rd_y_idx];

endmodule

// ===== hw/rtl/mm521_digit_mac.sv =====
// ----------------------------------------------------------------------------
// mm521_digit_mac
// Digit-serial multiply-accumulate: x times y, 15 bits of y per cycle.
// ----------------------------------------------------------------------------
module mm521_digit_mac import mm521_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  mac_ctl_t          ctl,
	input  logic [LIMB_W-1:0] x_op,
	input  logic [LIMB_W-1:0] y_op,
	output logic              rdy,
	output mac_res_t          res
);

	logic              busy_q;
	logic              dig_q;
	logic              dbl_q;
	logic              first_q;
	logic              last_q;
	logic [LIMB_W-1:0] x_q;
	logic [LIMB_W-1:0] y_sh_q;

	logic [PP_W-1:0]   pp_s1;
	logic              pp_v_s1;
	logic              pp_hi_s1;
	logic              pp_dbl_s1;
	logic              pp_first_s1;
	logic              pp_last_s1;

	logic [ACC_W-1:0]  acc_q;
	logic              done_q;
	logic [SHAMT_W-1:0] shamt;
	logic [ACC_W-1:0]  addend;

	// next term may load on the cycle its predecessor's high digit multiplies
	assign rdy = !busy_q || dig_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			dig_q   <= 1'b0;
			pp_v_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			if (ctl.load) begin
				busy_q <= 1'b1;
				dig_q  <= 1'b0;
			end else if (busy_q) begin
				dig_q <= !dig_q;
				if (dig_q)
					busy_q <= 1'b0;
			end
			pp_v_s1 <= busy_q;
			done_q  <= pp_v_s1 && pp_last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			x_q     <= x_op;
			y_sh_q  <= y_op;
			dbl_q   <= ctl.dbl;
			first_q <= ctl.first;
			last_q  <= ctl.last;
		end else if (busy_q) begin
			y_sh_q <= y_sh_q >> DIG_W;
		end
		pp_s1       <= PP_W'(x_q) * PP_W'(y_sh_q[DIG_W-1:0]);
		pp_hi_s1    <= dig_q;
		pp_dbl_s1   <= dbl_q;
		pp_first_s1 <= first_q && !dig_q;
		pp_last_s1  <= last_q && dig_q;
	end

	// weight of the digit, plus one for wrapped terms that count twice
	assign shamt  = (pp_hi_s1 ? SHAMT_W'(DIG_W) : '0) + SHAMT_W'(pp_dbl_s1);
	assign addend = ACC_W'(pp_s1) << shamt;

	always_ff @(posedge clk) begin
		if (pp_v_s1)
			acc_q <= (pp_first_s1 ? '0 : acc_q) + addend;
	end

	assign res.valid = done_q;
	assign res.sum   = acc_q;

endmodule

// ===== hw/rtl/mm521_carry_chain.sv =====
// ----------------------------------------------------------------------------
// mm521_carry_chain
// Carry propagation over column sums, top carry fold, product limb store.
// ----------------------------------------------------------------------------
module mm521_carry_chain import mm521_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  mac_res_t          col,
	input  logic [IDX_W-1:0]  rd_idx,
	output logic [LIMB_W-1:0] rd_limb,
	output logic              done
);

	cc_state_t         state_q;
	cc_state_t         state_d;
	logic [IDX_W-1:0]  seq_q;
	logic [IDX_W-1:0]  seq_d;
	logic              col_take;

	logic [ACC_W-1:0]  t_q;
	logic [CARRY_W-1:0] c_q;
	logic [LIMB_W-1:0] prod_q [LIMB_COUNT];
	logic [ACC_W-1:0]  t_in;
	logic [ACC_W-1:0]  t_new;
	logic [IDX_W-1:0]  wr_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CC_COL;
			seq_q   <= '0;
		end else begin
			state_q <= state_d;
			seq_q   <= seq_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		seq_d    = seq_q;
		col_take = 1'b0;
		done     = 1'b0;
		unique case (state_q)
			CC_COL: begin
				if (col.valid) begin
					col_take = 1'b1;
					if (seq_q == LAST_POS) begin
						seq_d   = '0;
						state_d = CC_FOLD;
					end else begin
						seq_d = seq_q + 1'b1;
					end
				end
			end
			CC_FOLD: state_d = CC_FIX;
			CC_FIX: begin
				done    = 1'b1;
				state_d = CC_COL;
			end
			default: state_d = CC_COL;
		endcase
	end

	// column 17 comes first and hands on its carry from bit 28 up
	assign t_in   = (seq_q == 5'd1) ? (t_q >> (LIMB_BITS - 1)) : (t_q >> LIMB_BITS);
	assign t_new  = col.sum + t_in;
	assign wr_idx = seq_q - 1'b1;

	always_ff @(posedge clk) begin
		if (col_take) begin
			if (seq_q == FIRST_POS) begin
				t_q <= col.sum;
				c_q <= CARRY_W'(col.sum[LIMB_BITS-2:0]);
			end else begin
				t_q            <= t_new;
				prod_q[wr_idx] <= t_new[LIMB_W-1:0] & MASK_MID;
			end
		end
		if (state_q == CC_FOLD)
			c_q <= c_q + CARRY_W'(t_q >> LIMB_BITS);
		if (state_q == CC_FIX) begin
			prod_q[LIMB_COUNT-1] <= LIMB_W'(c_q[LIMB_BITS-2:0]);
			prod_q[0]            <= prod_q[0] + LIMB_W'(c_q >> (LIMB_BITS - 1));
		end
	end

	assign rd_limb = prod_q[rd_idx];

endmodule

// ===== hw/rtl/mersenne521_modular_multiplier_top.sv =====
// ----------------------------------------------------------------------------
// mersenne521_modular_multiplier_top
// Multiplier modulo 2^521-1 on 18 limbs of radix 2^29, digit-serial datapath.
// ----------------------------------------------------------------------------
// Limb pairs load one per cycle; a transfer at position 17 starts the product
// and the block takes no further limb until all 18 result limbs have gone into
// the output register. The product runs 324 limb products through one 30x15
// multiplier, a digit at a time, and a term loads while the one before it
// finishes its high digit. The 18 results then transfer one a cycle when the
// sink keeps up. A limb index above 17 is accepted and dropped. Limbs never
// written since reset read as unknown. Limb 0 of the result may use 30 bits.
module mersenne521_modular_multiplier_top import mm521_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              limb_valid,
	output logic              limb_ready,
	input  logic [IDX_W-1:0]  limb_index,
	input  logic [LIMB_W-1:0] x_limb,
	input  logic [LIMB_W-1:0] y_limb,
	output logic              result_valid,
	input  logic              result_ready,
	output logic [LIMB_W-1:0] z_limb,
	output logic [IDX_W-1:0]  result_position,
	output logic              last_limb
);

	seq_state_t        state_q;
	seq_state_t        state_d;
	logic [IDX_W-1:0]  term_q;
	logic [IDX_W-1:0]  term_d;
	logic [IDX_W-1:0]  col_q;
	logic [IDX_W-1:0]  col_d;
	logic [IDX_W-1:0]  out_cnt_q;
	logic [IDX_W-1:0]  out_cnt_d;

	logic              in_xfer;
	logic              wr_en;
	logic [IDX_W-1:0]  col_k;
	logic [IDX_W-1:0]  y_idx;
	logic [LIMB_W-1:0] x_rd;
	logic [LIMB_W-1:0] y_rd;
	mac_ctl_t          mac_ctl;
	logic              mac_rdy;
	mac_res_t          mac_res;
	logic [LIMB_W-1:0] prod_rd;
	logic              cc_done;
	logic              out_load;

	logic              res_valid_q;
	logic [LIMB_W-1:0] z_q;
	logic [IDX_W-1:0]  pos_q;
	logic              last_q;

	assign in_xfer = limb_valid && limb_ready;
	assign wr_en   = in_xfer && (limb_index < POS_COUNT);

	// columns run 17, 0, 1 .. 16; index j wraps for the doubled terms
	assign col_k = (col_q == FIRST_POS) ? LAST_POS : col_q - 1'b1;
	assign y_idx = (term_q <= col_k) ? col_k - term_q : col_k - term_q + POS_COUNT;

	mm521_limb_file u_limb_file (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_idx   (limb_index),
		.wr_x     (x_limb),
		.wr_y     (y_limb),
		.rd_x_idx (term_q),
		.rd_y_idx (y_idx),
		.x_rd     (x_rd),
		.y_rd     (y_rd)
	);

	mm521_digit_mac u_digit_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.x_op   (x_rd),
		.y_op   (y_rd),
		.rdy    (mac_rdy),
		.res    (mac_res)
	);

	mm521_carry_chain u_carry_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.col     (mac_res),
		.rd_idx  (out_cnt_q),
		.rd_limb (prod_rd),
		.done    (cc_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= SEQ_IDLE;
			term_q    <= '0;
			col_q     <= '0;
			out_cnt_q <= '0;
		end else begin
			state_q   <= state_d;
			term_q    <= term_d;
			col_q     <= col_d;
			out_cnt_q <= out_cnt_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		term_d        = term_q;
		col_d         = col_q;
		out_cnt_d     = out_cnt_q;
		limb_ready    = 1'b0;
		out_load      = 1'b0;
		mac_ctl.load  = 1'b0;
		mac_ctl.dbl   = term_q > col_k;
		mac_ctl.first = term_q == FIRST_POS;
		mac_ctl.last  = term_q == LAST_POS;
		unique case (state_q)
			SEQ_IDLE: begin
				limb_ready = 1'b1;
				if (limb_valid && limb_index == LAST_POS) begin
					term_d  = '0;
					col_d   = '0;
					state_d = SEQ_ISSUE;
				end
			end
			SEQ_ISSUE: begin
				if (mac_rdy) begin
					mac_ctl.load = 1'b1;
					if (term_q == LAST_POS) begin
						term_d = '0;
						col_d  = col_q + 1'b1;
						if (col_q == LAST_POS)
							state_d = SEQ_DRAIN;
					end else begin
						term_d = term_q + 1'b1;
					end
				end
			end
			SEQ_DRAIN: begin
				if (cc_done) begin
					out_cnt_d = '0;
					state_d   = SEQ_OUT;
				end
			end
			SEQ_OUT: begin
				if (!res_valid_q || result_ready) begin
					out_load  = 1'b1;
					out_cnt_d = out_cnt_q + 1'b1;
					if (out_cnt_q == LAST_POS)
						state_d = SEQ_IDLE;
				end
			end
			default: state_d = SEQ_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (out_load)
			res_valid_q <= 1'b1;
		else if (result_ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			z_q    <= prod_rd;
			pos_q  <= out_cnt_q;
			last_q <= out_cnt_q == LAST_POS;
		end
	end

	assign result_valid    = res_valid_q;
	assign z_limb          = z_q;
	assign result_position = pos_q;
	assign last_limb       = last_q;

endmodule

// ===== hw/rtl/mm521_checker.sv =====
// ----------------------------------------------------------------------------
// mm521_checker
// Port-level checks of the modulo 2^521-1 multiplier, bound to the top level.
// ----------------------------------------------------------------------------
module mm521_checker import mm521_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              limb_valid,
	input logic              limb_ready,
	input logic [IDX_W-1:0]  limb_index,
	input logic              result_valid,
	input logic              result_ready,
	input logic [LIMB_W-1:0] z_limb,
	input logic [IDX_W-1:0]  result_position,
	input logic              last_limb
);

	logic [IDX_W-1:0] exp_pos_q;

	// position the next result limb must carry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			exp_pos_q <= '0;
		else if (result_valid && result_ready)
			exp_pos_q <= last_limb ? FIRST_POS : result_position + 1'b1;
	end

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(z_limb) &&
		$stable(result_position) && $stable(last_limb))
		else $error("result changed or dropped before transfer");

	a_result_order: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result_position == exp_pos_q)
		else $error("result limb out of order");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> last_limb == (result_position == LAST_POS))
		else $error("last_limb does not match position");

	a_limb_width: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result_position == FIRST_POS) ||
		(!z_limb[LIMB_W-1] && ((result_position != LAST_POS) || !z_limb[LIMB_W-2])))
		else $error("result limb wider than its position allows");

	a_start_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		limb_valid && limb_ready && limb_index == LAST_POS |=> !limb_ready)
		else $error("limb taken while product in progress");

endmodule

bind mersenne521_modular_multiplier_top mm521_checker u_mm521_checker (.*);

// ===== sim/tb_mersenne521_modular_multiplier_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mersenne521_modular_multiplier_top
// Self-checking bench for the modulo 2^521-1 limb multiplier.
// ----------------------------------------------------------------------------
// Limb pairs are queued up front and sent by a clocked driver. Each accepted
// pair updates the bench's own operand stores. A pair at position 17 computes
// the reduced product and queues its 18 result limbs. A clocked monitor then
// compares every result transfer against the oldest queued limb.
// The stimulus is a short directed part, then full and partial operand
// loads with random content and some dropped indexes. It runs through
// phases of sender and receiver idling, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_mersenne521_modular_multiplier_top;
	import mm521_pkg::*;

	typedef struct {
		logic [IDX_W-1:0]  idx;
		logic [LIMB_W-1:0] x;
		logic [LIMB_W-1:0] y;
		int                phase;
	} limb_pair_t;

	typedef struct {
		logic [LIMB_W-1:0] z;
		logic [IDX_W-1:0]  pos;
		logic              last;
	} zlimb_t;

	localparam int LIMB_TARGET = 330;
	localparam int HOLD_CYCLES = 2000;

	logic              clk;
	logic              arst_n;
	logic              limb_valid;
	logic              limb_ready;
	logic [IDX_W-1:0]  limb_index;
	logic [LIMB_W-1:0] x_limb;
	logic [LIMB_W-1:0] y_limb;
	logic              result_valid;
	logic              result_ready;
	logic [LIMB_W-1:0] z_limb;
	logic [IDX_W-1:0]  result_position;
	logic              last_limb;

	mersenne521_modular_multiplier_top dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.limb_valid      (limb_valid),
		.limb_ready      (limb_ready),
		.limb_index      (limb_index),
		.x_limb          (x_limb),
		.y_limb          (y_limb),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.z_limb          (z_limb),
		.result_position (result_position),
		.last_limb       (last_limb)
	);

	// operand stores as the block should hold them
	logic [LIMB_W-1:0] x_store [LIMB_COUNT];
	logic [LIMB_W-1:0] y_store [LIMB_COUNT];

	limb_pair_t pending_pairs [$];
	zlimb_t     product_q [$];
	limb_pair_t next_pair;
	zlimb_t     want;

	int  limbs_queued;
	int  pairs_loaded;
	int  indexes_dropped;
	int  products_started;
	int  limbs_checked;
	int  errors;
	int  cur_phase;
	int  hold_left;
	bit  hold_done;
	bit  limb_took;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#15_000_000;
		$display("timeout with %0d result limbs outstanding", product_q.size());
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic flag_mismatch(input string msg);
		errors++;
		if (errors <= 40)
			$display("mismatch: %s", msg);
	endtask

	function automatic logic [ACC_W-1:0] column_sum(input int k);
		logic [ACC_W-1:0] s;
		int i;
		s = '0;
		for (i = 0; i < LIMB_COUNT; i++) begin
			if (i <= k)
				s += ACC_W'(x_store[i]) * ACC_W'(y_store[k - i]);
			else
				s += (ACC_W'(x_store[i]) * ACC_W'(y_store[k + LIMB_COUNT - i])) << 1;
		end
		return s;
	endfunction

	// column 17 first, its carry wraps into column 0, top carry folds into limb 0
	task automatic reduce_product();
		logic [ACC_W-1:0] t;
		logic [ACC_W-1:0] c;
		logic [ACC_W-1:0] z [LIMB_COUNT];
		zlimb_t r;
		int k;
		t = column_sum(LIMB_COUNT - 1);
		c = t & ACC_W'(MASK_TOP);
		t = column_sum(0) + (t >> (LIMB_BITS - 1));
		z[0] = t & ACC_W'(MASK_MID);
		for (k = 1; k < LIMB_COUNT - 1; k++) begin
			t = column_sum(k) + (t >> LIMB_BITS);
			z[k] = t & ACC_W'(MASK_MID);
		end
		c += t >> LIMB_BITS;
		z[LIMB_COUNT - 1] = c & ACC_W'(MASK_TOP);
		z[0] = (z[0] + (c >> (LIMB_BITS - 1))) & ACC_W'(MASK_LOW);
		for (k = 0; k < LIMB_COUNT; k++) begin
			r.z    = LIMB_W'(z[k]);
			r.pos  = IDX_W'(k);
			r.last = (k == LIMB_COUNT - 1);
			product_q.push_back(r);
		end
	endtask

	task automatic load_limb_pair(input logic [IDX_W-1:0] idx, input logic [LIMB_W-1:0] x,
			input logic [LIMB_W-1:0] y);
		logic [LIMB_W-1:0] m;
		if (idx >= POS_COUNT) begin
			indexes_dropped++;
		end else begin
			if (idx == FIRST_POS)
				m = MASK_LOW;
			else if (idx == LAST_POS)
				m = MASK_TOP;
			else
				m = MASK_MID;
			x_store[idx] = x & m;
			y_store[idx] = y & m;
			pairs_loaded++;
			if (idx == LAST_POS) begin
				products_started++;
				reduce_product();
			end
		end
	endtask

	function automatic int sender_idle_pct(input int ph);
		return (ph == 1) ? 65 : (ph == 3) ? 18 : 0;
	endfunction

	function automatic int receiver_stall_pct(input int ph);
		return (ph == 2) ? 65 : (ph == 3) ? 18 : 0;
	endfunction

	function automatic logic [LIMB_W-1:0] draw_limb();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return LIMB_W'($urandom);
		endcase
	endfunction

	task automatic queue_pair(input logic [IDX_W-1:0] idx, input logic [LIMB_W-1:0] x,
			input logic [LIMB_W-1:0] y);
		limb_pair_t p;
		p.idx = idx;
		p.x   = x;
		p.y   = y;
		if (limbs_queued < 110)
			p.phase = 0;
		else if (limbs_queued < 185)
			p.phase = 1;
		else if (limbs_queued < 260)
			p.phase = 2;
		else
			p.phase = 3;
		if (idx < POS_COUNT)
			limbs_queued++;
		pending_pairs.push_back(p);
	endtask

	// sender
	always @(negedge clk) begin
		if (arst_n) begin
			if (!limb_valid || limb_took) begin
				limb_took = 1'b0;
				if (pending_pairs.size() != 0 &&
						$urandom_range(99) >= sender_idle_pct(pending_pairs[0].phase)) begin
					next_pair = pending_pairs.pop_front();
					limb_valid <= 1'b1;
					limb_index <= next_pair.idx;
					x_limb     <= next_pair.x;
					y_limb     <= next_pair.y;
					cur_phase  <= next_pair.phase;
				end else begin
					limb_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off once the second product is under way
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
			end else if (!hold_done && products_started >= 2) begin
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (arst_n)
			result_ready <= (hold_left == 0) && ($urandom_range(99) >= receiver_stall_pct(cur_phase));
	end

	// monitor: results checked before a new transfer adds expectations
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (product_q.size() == 0) begin
					flag_mismatch($sformatf("unexpected result limb, position %0d", result_position));
				end else begin
					want = product_q.pop_front();
					limbs_checked++;
					if (z_limb !== want.z)
						flag_mismatch($sformatf("z_limb at %0d: got %h want %h",
							want.pos, z_limb, want.z));
					if (result_position !== want.pos)
						flag_mismatch($sformatf("result_position: got %0d want %0d",
							result_position, want.pos));
					if (last_limb !== want.last)
						flag_mismatch($sformatf("last_limb at %0d: got %b want %b",
							want.pos, last_limb, want.last));
				end
			end
			if (limb_valid && limb_ready) begin
				limb_took = 1'b1;
				load_limb_pair(limb_index, x_limb, y_limb);
			end
		end
	end

	initial begin
		int order [LIMB_COUNT - 1];
		int i;
		int j;
		int tmp;
		int kind;
		int n;
		arst_n       = 1'b0;
		limb_valid   = 1'b0;
		limb_index   = '0;
		x_limb       = '0;
		y_limb       = '0;
		result_ready = 1'b0;
		cur_phase    = 0;
		hold_left    = 0;
		hold_done    = 1'b0;
		limb_took    = 1'b0;
		limbs_queued = 0;
		pairs_loaded = 0;
		indexes_dropped  = 0;
		products_started = 0;
		limbs_checked    = 0;
		errors           = 0;

		// directed: all ones everywhere, oversized bits must be dropped
		for (i = 0; i < LIMB_COUNT; i++)
			queue_pair(IDX_W'(i), '1, '1);
		// indexes past the top are dropped
		queue_pair('1, '1, '1);
		queue_pair(POS_COUNT, '0, '0);
		// stores persist: first only the top limb changes, then limbs 0, 5 and 17
		queue_pair(LAST_POS, '0, '1);
		queue_pair(FIRST_POS, '0, '0);
		queue_pair(IDX_W'(5), '1, '0);
		queue_pair(LAST_POS, '1, '1);

		while (limbs_queued < LIMB_TARGET) begin
			kind = $urandom_range(99);
			if (kind < 55) begin
				// full operand load, in order or shuffled, top limb last
				for (i = 0; i < LIMB_COUNT - 1; i++)
					order[i] = i;
				if ($urandom_range(1)) begin
					for (i = LIMB_COUNT - 2; i > 0; i--) begin
						j = $urandom_range(i);
						tmp = order[i];
						order[i] = order[j];
						order[j] = tmp;
					end
				end
				for (i = 0; i < LIMB_COUNT - 1; i++)
					queue_pair(IDX_W'(order[i]), draw_limb(), draw_limb());
				queue_pair(LAST_POS, draw_limb(), draw_limb());
			end else if (kind < 80) begin
				n = $urandom_range(5, 1);
				repeat (n)
					queue_pair(IDX_W'($urandom_range(LIMB_COUNT - 2)), draw_limb(), draw_limb());
				queue_pair(LAST_POS, draw_limb(), draw_limb());
			end else if (kind < 92) begin
				queue_pair(IDX_W'($urandom_range(31, LIMB_COUNT)), draw_limb(), draw_limb());
			end else begin
				queue_pair(IDX_W'($urandom_range(LIMB_COUNT - 2)), draw_limb(), draw_limb());
			end
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_pairs.size() != 0 || limb_valid)
			@(posedge clk);
		while (product_q.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		$display("sent %0d limb pairs and %0d dropped indexes, %0d products reduced",
			pairs_loaded, indexes_dropped, products_started);
		$display("checked %0d result limbs across four idling phases, %0d mismatches",
			limbs_checked, errors);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
